// File: rtl/smoothstep_alpha_shaper_defines.svh
// Assertion helpers shared by the shaper modules.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef SMOOTHSTEP_ALPHA_SHAPER_DEFINES_SVH
`define SMOOTHSTEP_ALPHA_SHAPER_DEFINES_SVH

// Same-cycle implication
`define SSASH_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed in %m");

// Next-cycle implication
`define SSASH_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed in %m");

`endif

// File: rtl/ssash_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssash_pkg;

    // Fixed-point format
    localparam int FRAC_BITS = 16;
    localparam int ONE       = 1 << FRAC_BITS;

    // Field and datapath widths
    localparam int PIX_W      = 8;
    localparam int MIX_W      = 17;
    localparam int SOFT_W     = 18;
    localparam int EDGE_W     = 18;   // signed edge position, studio luma goes negative
    localparam int DIST_W     = 19;   // signed mix minus edge
    localparam int Q_W        = 17;   // ramp fraction 0 .. ONE
    localparam int SLOPE_W    = 18;   // 3*ONE - 2*v
    localparam int CODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_RANGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOFTNESS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 3'd4;

    // Register reset values
    localparam logic [MIX_W-1:0]  MIX_RESET  = MIX_W'(ONE);
    localparam logic [SOFT_W-1:0] SOFT_RESET = 18'd6554;

    // Ramp outcome codes decided before the divider
    localparam logic [CODE_W-1:0] RAMP_ZERO = 2'd0;   // mix below the edge
    localparam logic [CODE_W-1:0] RAMP_ONE  = 2'd1;   // past the ramp or hard step
    localparam logic [CODE_W-1:0] RAMP_CALC = 2'd2;   // on the ramp, use the quotient

    // Per-pixel sideband that rides along the pipeline
    typedef struct packed {
        logic [PIX_W-1:0]  alpha;
        logic [CODE_W-1:0] code;
        logic              bypass;
    } side_t;

    // Mask byte to edge position tables
    typedef logic signed [EDGE_W-1:0] edge_tab_t [256];

    function automatic edge_tab_t build_alpha_tab();
        edge_tab_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = EDGE_W'((i * ONE) / 255);
        end
        return t;
    endfunction

    function automatic edge_tab_t build_studio_tab();
        edge_tab_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = EDGE_W'(((i - 16) * ONE) / 235);
        end
        return t;
    endfunction

    localparam edge_tab_t ALPHA_TAB  = build_alpha_tab();
    localparam edge_tab_t STUDIO_TAB = build_studio_tab();

endpackage

`default_nettype wire

// File: rtl/smoothstep_alpha_shaper.sv
`timescale 1ns / 1ps
`default_nettype none

`include "smoothstep_alpha_shaper_defines.svh"

// Pipeline from request acceptance to out_valid: 2 front stages,
//   17 divider stages, 2 smoothstep multiply stages, output register.
// Throughput: one pixel per cycle while in_ready is high; the 17-stage restoring divider is fully pipelined.
// A one-entry skid register keeps in_ready registered and drops it only when full.
// Reset (rst_n low, asynchronous) empties the pipeline and loads register defaults.
module smoothstep_alpha_shaper (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ssash_pkg::PIX_W-1:0]      pixel_alpha,
    input  logic [ssash_pkg::PIX_W-1:0]      mask_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ssash_pkg::PIX_W-1:0]      alpha_out,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ssash_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssash_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ssash_pkg::*;

    // Configuration registers
    logic              luma_mode_reg;
    logic              full_range_reg;
    logic [MIX_W-1:0]  mix_reg;
    logic [SOFT_W-1:0] soft_reg;
    logic              invert_reg;

    // Pipeline control
    logic adv;
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic out_vld_reg, skid_vld_reg;

    // Stage 1: edge and ramp width
    logic [PIX_W-1:0]         alpha1_reg;
    logic signed [EDGE_W-1:0] edge1_reg;
    logic [SOFT_W-1:0]        soft1_reg;
    logic                     byp1_reg;
    logic [MIX_W-1:0]         mix_rem;
    logic [SOFT_W+MIX_W-1:0]  s_prod;
    logic [SOFT_W-1:0]        soft_next;
    logic signed [EDGE_W-1:0] edge_next;
    logic                     byp_next;

    // Stage 2: classify against the ramp
    side_t                    side2_reg;
    logic [SOFT_W-1:0]        num2_reg;
    logic [SOFT_W-1:0]        den2_reg;
    logic signed [DIST_W-1:0] mix_gap;
    logic [CODE_W-1:0]        code_next;
    logic [SOFT_W-1:0]        num_next;

    // Divider output
    logic           div_vld;
    side_t          div_side;
    logic [Q_W-1:0] div_quo;

    // Stage 3 and 4: smoothstep polynomial
    side_t                  side3_reg, side4_reg;
    logic [Q_W-1:0]         v2_3_reg;
    logic [SLOPE_W-1:0]     slope3_reg;
    logic [Q_W-1:0]         ramp4_reg;
    logic [2*Q_W-1:0]       sq_prod;
    logic [Q_W+SLOPE_W-1:0] cub_prod;

    // Output stage
    logic [Q_W-1:0]       ramp_sel;
    logic [Q_W-1:0]       factor;
    logic [PIX_W+Q_W-1:0] scaled;
    logic [PIX_W-1:0]     shaped;
    logic [PIX_W-1:0]     fin_next;
    logic [PIX_W-1:0]     out_data_reg, skid_data_reg;

    // Write configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_mode_reg  <= 1'b0;
            full_range_reg <= 1'b0;
            mix_reg        <= MIX_RESET;
            soft_reg       <= SOFT_RESET;
            invert_reg     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LUMA_MODE:  luma_mode_reg  <= cfg_data[0];
                REG_FULL_RANGE: full_range_reg <= cfg_data[0];
                REG_MIX_LEVEL:  mix_reg        <= cfg_data[MIX_W-1:0];
                REG_SOFTNESS:   soft_reg       <= cfg_data[SOFT_W-1:0];
                REG_INVERT:     invert_reg     <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Advance whenever the skid register is free
    assign adv      = !skid_vld_reg;
    assign in_ready = adv;

    // Look up the edge and, in luma mode, scale the ramp width
    always_comb
    begin
        mix_rem   = MIX_W'(ONE) - mix_reg;
        s_prod    = (SOFT_W+MIX_W)'(soft_reg) * (SOFT_W+MIX_W)'(mix_rem);
        soft_next = luma_mode_reg ? s_prod[FRAC_BITS +: SOFT_W] : soft_reg;
        edge_next = (luma_mode_reg && !full_range_reg) ? STUDIO_TAB[mask_value]
                                                       : ALPHA_TAB[mask_value];
        byp_next  = luma_mode_reg && (mix_reg >= MIX_W'(ONE));
    end

    // Classify mix against the ramp from edge to edge plus width
    always_comb
    begin
        mix_gap = $signed({2'b00, mix_reg}) - $signed({edge1_reg[EDGE_W-1], edge1_reg});
        if (mix_gap[DIST_W-1])
        begin
            code_next = RAMP_ZERO;
        end
        else if (soft1_reg == '0)
        begin
            code_next = RAMP_ONE;
        end
        else if (mix_gap[SOFT_W-1:0] > soft1_reg)
        begin
            code_next = RAMP_ONE;
        end
        else
        begin
            code_next = RAMP_CALC;
        end
        num_next = (code_next == RAMP_CALC) ? mix_gap[SOFT_W-1:0] : '0;
    end

    // Ramp position v = distance / width in Q16
    ssash_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (vld2_reg),
        .in_side  (side2_reg),
        .in_num   (num2_reg),
        .in_den   (den2_reg),
        .out_vld  (div_vld),
        .out_side (div_side),
        .out_quo  (div_quo)
    );

    // Square the position and form the cubic slope term
    assign sq_prod  = (2*Q_W)'(div_quo) * (2*Q_W)'(div_quo);
    assign cub_prod = (Q_W+SLOPE_W)'(v2_3_reg) * (Q_W+SLOPE_W)'(slope3_reg);

    // Pick the factor, scale alpha, apply invert and full-mix bypass
    always_comb
    begin
        case (side4_reg.code)
            RAMP_ZERO: ramp_sel = '0;
            RAMP_ONE:  ramp_sel = Q_W'(ONE);
            RAMP_CALC: ramp_sel = ramp4_reg;
            default:   ramp_sel = '0;
        endcase
        factor   = luma_mode_reg ? ramp_sel : Q_W'(ONE) - ramp_sel;
        scaled   = (PIX_W+Q_W)'(side4_reg.alpha) * (PIX_W+Q_W)'(factor);
        shaped   = scaled[FRAC_BITS +: PIX_W] ^ {PIX_W{invert_reg}};
        fin_next = side4_reg.bypass ? side4_reg.alpha : shaped;
    end

    // Advance pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= div_vld;
            vld4_reg <= vld3_reg;
        end
    end

    // Advance pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            alpha1_reg       <= pixel_alpha;
            edge1_reg        <= edge_next;
            soft1_reg        <= soft_next;
            byp1_reg         <= byp_next;
            side2_reg.alpha  <= alpha1_reg;
            side2_reg.code   <= code_next;
            side2_reg.bypass <= byp1_reg;
            num2_reg         <= num_next;
            den2_reg         <= soft1_reg;
            side3_reg        <= div_side;
            v2_3_reg         <= sq_prod[FRAC_BITS +: Q_W];
            slope3_reg       <= SLOPE_W'(3 * ONE) - {div_quo, 1'b0};
            side4_reg        <= side3_reg;
            ramp4_reg        <= cub_prod[FRAC_BITS +: Q_W];
        end
    end

    // Output register with one-entry skid: park a result when the output is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (out_ready)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
        else if (vld4_reg)
        begin
            if (out_vld_reg && !out_ready)
            begin
                skid_vld_reg <= 1'b1;
            end
            else
            begin
                out_vld_reg <= 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (out_ready)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (vld4_reg)
        begin
            if (out_vld_reg && !out_ready)
            begin
                skid_data_reg <= fin_next;
            end
            else
            begin
                out_data_reg <= fin_next;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign alpha_out = out_data_reg;

    `SSASH_ASSERT_IMPL(a_skid_implies_out, skid_vld_reg, out_vld_reg)
    `SSASH_ASSERT_NEXT(a_skid_drains, skid_vld_reg && out_ready, !skid_vld_reg && out_vld_reg)
    `SSASH_ASSERT_NEXT(a_skid_stays_empty, !skid_vld_reg && (!out_vld_reg || out_ready), !skid_vld_reg)

endmodule

`default_nettype wire

// File: rtl/ssash_div.sv
`timescale 1ns / 1ps
`default_nettype none

`include "smoothstep_alpha_shaper_defines.svh"

// Restoring divider, one quotient bit per stage: quo = (num << FRAC_BITS) / den
// for num <= den, so the quotient spans 0 .. ONE.
module ssash_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_vld,
    input  ssash_pkg::side_t             in_side,
    input  logic [ssash_pkg::SOFT_W-1:0] in_num,
    input  logic [ssash_pkg::SOFT_W-1:0] in_den,
    output logic                         out_vld,
    output ssash_pkg::side_t             out_side,
    output logic [ssash_pkg::Q_W-1:0]    out_quo
);
    import ssash_pkg::*;

    localparam int DIV_BITS = Q_W;
    localparam int REM_W    = SOFT_W + 1;

    logic              vld_reg  [DIV_BITS];
    side_t             side_reg [DIV_BITS];
    logic [Q_W-1:0]    quo_reg  [DIV_BITS];
    logic [REM_W-1:0]  rem_reg  [DIV_BITS-1];
    logic [SOFT_W-1:0] den_reg  [DIV_BITS-1];

    logic [REM_W-1:0]    rem_in [DIV_BITS];
    logic [SOFT_W-1:0]   den_in [DIV_BITS];
    logic [Q_W-1:0]      quo_in [DIV_BITS];
    logic [Q_W-1:0]      quo_nx [DIV_BITS];
    logic [REM_W-1:0]    rem_nx [DIV_BITS-1];
    logic [DIV_BITS-1:0] ge;

    // Select each stage's operands and do one compare-subtract step
    always_comb
    begin
        rem_in[0] = {1'b0, in_num};
        den_in[0] = in_den;
        quo_in[0] = '0;
        for (int k = 1; k < DIV_BITS; k++)
        begin
            rem_in[k] = rem_reg[k-1];
            den_in[k] = den_reg[k-1];
            quo_in[k] = quo_reg[k-1];
        end
        for (int k = 0; k < DIV_BITS; k++)
        begin
            ge[k]     = rem_in[k] >= {1'b0, den_in[k]};
            quo_nx[k] = {quo_in[k][Q_W-2:0], ge[k]};
        end
        for (int k = 0; k < DIV_BITS - 1; k++)
        begin
            if (ge[k])
            begin
                rem_nx[k] = (rem_in[k] - {1'b0, den_in[k]}) << 1;
            end
            else
            begin
                rem_nx[k] = rem_in[k] << 1;
            end
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_BITS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k < DIV_BITS; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= in_side;
            for (int k = 1; k < DIV_BITS; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 0; k < DIV_BITS; k++)
            begin
                quo_reg[k] <= quo_nx[k];
            end
            for (int k = 0; k < DIV_BITS - 1; k++)
            begin
                rem_reg[k] <= rem_nx[k];
                den_reg[k] <= den_in[k];
            end
        end
    end

    assign out_vld  = vld_reg[DIV_BITS-1];
    assign out_side = side_reg[DIV_BITS-1];
    assign out_quo  = quo_reg[DIV_BITS-1];

    `SSASH_ASSERT_IMPL(a_calc_operands, in_vld && (in_side.code == RAMP_CALC), (in_num <= in_den) && (in_den != '0))
    `SSASH_ASSERT_IMPL(a_quo_range, out_vld && (out_side.code == RAMP_CALC), out_quo <= Q_W'(ONE))
    `SSASH_ASSERT_NEXT(a_hold_on_stall, !adv, $stable(out_quo) && $stable(out_vld))

endmodule

`default_nettype wire
